// ===== src/lcd_nibble_write_queue_core_macros.svh =====
// Assertion macros shared by the display write queue modules.
`ifndef LCD_NIBBLE_WRITE_QUEUE_CORE_MACROS_SVH
`define LCD_NIBBLE_WRITE_QUEUE_CORE_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define LCDQ_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define LCDQ_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// ===== src/lcdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdq_pkg
// Types and constants shared by the display nibble write queue.
// ----------------------------------------------------------------------------
package lcdq_pkg;

    localparam int BYTE_W              = 8;
    localparam int WORD_W              = 7;
    localparam int DEFAULT_QUEUE_DEPTH = 32;

    // Operation codes on the request channel.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Bit positions in the byte and in the port word.
    localparam int CMD_FLAG_BIT = 7;
    localparam int RS_BIT       = 4;
    localparam int EN_BIT       = 6;

    // Output word sequence of one byte.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_HI_PULSE = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LO_FIRST = 3'd3;
    localparam logic [STEP_W-1:0] STEP_LO_PULSE = 3'd4;
    localparam logic [STEP_W-1:0] STEP_LAST     = 3'd6;

    typedef struct packed {
        logic enq;        // write the request byte at the tail
        logic deq;        // read the head byte and restart the word sequence
        logic step_inc;   // advance to the next output word
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_step;
    } sts_t;

endpackage

// ===== src/lcd_nibble_write_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_nibble_write_queue_core
// Byte queue driving a 4-bit character display port, a word per ready cycle.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (s_valid, s_ready, s_op, s_byte_in) carries two kinds of
// requests. An enqueue request stores s_byte_in at the tail of a ring buffer of
// QUEUE_DEPTH bytes; when the buffer is full the byte is dropped. A tick request
// removes the oldest byte and produces seven words on the result channel
// (m_valid, m_ready, m_port_word, m_last_word): high nibble, high nibble with
// enable, high nibble, the same three for the low nibble, then an all-zero word
// flagged by m_last_word. Bit 4 is register select, set for data bytes (bit 7
// clear). A tick on an empty buffer produces nothing.
// Timing: an enqueue or an empty tick leaves the sequencer idle. A tick that
// pops a byte reads the buffer memory in its accept cycle and shows the
// seven words from the next cycle on, one word per cycle while m_ready is
// high. Requests are not taken while words are being delivered; a stall on
// m_ready simply holds the current word.
// Reset (synchronous, active low) empties the queue and returns the sequencer
// to idle; the buffer contents are not cleared since they are never read
// before being written.
// ----------------------------------------------------------------------------

module lcd_nibble_write_queue_core #(
    parameter int QUEUE_DEPTH = lcdq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_op,
    input  logic [lcdq_pkg::BYTE_W-1:0] s_byte_in,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [lcdq_pkg::WORD_W-1:0] m_port_word,
    output logic                        m_last_word
);

    lcdq_pkg::cmd_t cmd;
    lcdq_pkg::sts_t sts;

    // Sequencer: decides which requests touch the buffer and paces the words.
    lcdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: buffer memory, pointers, fill count and word formatting.
    lcdq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_in   (s_byte_in),
        .cmd       (cmd),
        .sts       (sts),
        .port_word (m_port_word),
        .last_word (m_last_word)
    );

endmodule

// ===== src/lcdq_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdq_dp
// Ring buffer, pointers, fill count and port word generator.
// ----------------------------------------------------------------------------
`include "lcd_nibble_write_queue_core_macros.svh"

module lcdq_dp #(
    parameter int QUEUE_DEPTH = lcdq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [lcdq_pkg::BYTE_W-1:0] byte_in,
    input  lcdq_pkg::cmd_t              cmd,
    output lcdq_pkg::sts_t              sts,
    output logic [lcdq_pkg::WORD_W-1:0] port_word,
    output logic                        last_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [lcdq_pkg::BYTE_W-1:0] mem [QUEUE_DEPTH];

    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [lcdq_pkg::STEP_W-1:0] step_reg, step_next;
    logic [lcdq_pkg::BYTE_W-1:0] rd_data_reg;

    logic                        rs;
    logic [3:0]                  nibble;
    logic                        en;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        if (cmd.enq) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        if (cmd.deq) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            count_next  = count_reg - 1'b1;
            step_next   = '0;
        end else if (cmd.step_inc) begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            step_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enq) begin
            mem[wr_ptr_reg] <= byte_in;
        end
        if (cmd.deq) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign sts.full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign sts.empty     = (count_reg == '0);
    assign sts.last_step = (step_reg == lcdq_pkg::STEP_LAST);

    // Register select is high for data bytes, low for command bytes.
    always_comb begin
        rs        = ~rd_data_reg[lcdq_pkg::CMD_FLAG_BIT];
        nibble    = (step_reg < lcdq_pkg::STEP_LO_FIRST) ? rd_data_reg[7:4] : rd_data_reg[3:0];
        en        = (step_reg inside {lcdq_pkg::STEP_HI_PULSE, lcdq_pkg::STEP_LO_PULSE});
        port_word = '0;
        if (step_reg != lcdq_pkg::STEP_LAST) begin
            port_word[3:0]              = nibble;
            port_word[lcdq_pkg::RS_BIT] = rs;
            port_word[lcdq_pkg::EN_BIT] = en;
        end
        last_word = sts.last_step;
    end

    `LCDQ_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(QUEUE_DEPTH), "fill count above depth")
    `LCDQ_NEVER(a_enq_full, aclk, aresetn, cmd.enq && sts.full, "write into a full queue")
    `LCDQ_NEVER(a_deq_empty, aclk, aresetn, cmd.deq && sts.empty, "read from an empty queue")
    `LCDQ_ASSERT(a_count_inc, aclk, aresetn, (cmd.enq && !cmd.deq) |=> (count_reg == $past(count_reg) + 1'b1), "fill count did not grow")

endmodule

// ===== src/lcdq_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcdq_ctrl
// Sequencer: takes requests and steps through the seven port words.
// ----------------------------------------------------------------------------
`include "lcd_nibble_write_queue_core_macros.svh"

module lcdq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic           s_op,
    output logic           m_valid,
    input  logic           m_ready,
    input  lcdq_pkg::sts_t sts,
    output lcdq_pkg::cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_op == lcdq_pkg::OP_ENQUEUE) begin
                        cmd.enq = ~sts.full;
                    end else if (!sts.empty) begin
                        cmd.deq    = 1'b1;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (sts.last_step) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.step_inc = 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `LCDQ_NEVER(a_one_side, aclk, aresetn, s_ready && m_valid, "request and result sides open together")
    `LCDQ_ASSERT(a_deq_emits, aclk, aresetn, cmd.deq |=> (m_valid && !sts.last_step), "dequeue not followed by output")
    `LCDQ_ASSERT(a_last_idle, aclk, aresetn, (m_valid && m_ready && sts.last_step) |=> s_ready, "no return to idle after last word")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the display nibble write queue core. Requests are
// offered with random gaps, and every popped byte is predicted as its seven
// port words. A scoreboard compares each delivered word, in order, with the
// prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DEPTH        = lcdq_pkg::DEFAULT_QUEUE_DEPTH;
    localparam int IDLE_PCT     = 31;
    // The receiver holds off once, long enough for the sender to back up.
    localparam int HOLD_AT_WORD = 60;
    localparam int HOLD_CYCLES  = 300;
    // The receiver never stalls while this many words go by.
    localparam int CALM_FIRST   = 250;
    localparam int CALM_LAST    = 450;
    // A little slack after the last predicted word, before the verdict.
    localparam int SETTLE       = 20;
    // Longest quiet stretch of a correct run is the hold-off plus short stalls.
    localparam int QUIET_LIMIT  = 3000;

    typedef struct packed {
        logic [lcdq_pkg::WORD_W-1:0] port_word;
        logic                        last_word;
    } port_beat_t;

    // Tracks the byte queue and the words each popped byte must produce.
    class nibble_word_tracker;
        logic [lcdq_pkg::BYTE_W-1:0] byte_ring [DEPTH];
        int unsigned                 tail_slot;
        int unsigned                 head_slot;
        int unsigned                 fill;
        port_beat_t                  pending_words[$];
        int                          mismatches;

        function new();
            tail_slot  = 0;
            head_slot  = 0;
            fill       = 0;
            mismatches = 0;
        endfunction

        function void flag_mismatch(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, what);
        endfunction

        function void note_request(logic op, logic [lcdq_pkg::BYTE_W-1:0] data);
            logic [lcdq_pkg::BYTE_W-1:0] head_byte;
            logic [lcdq_pkg::WORD_W-1:0] hi_word;
            logic [lcdq_pkg::WORD_W-1:0] lo_word;
            logic [lcdq_pkg::WORD_W-1:0] hi_pulse;
            logic [lcdq_pkg::WORD_W-1:0] lo_pulse;
            if (op == lcdq_pkg::OP_ENQUEUE) begin
                // A full queue drops the byte without any other effect.
                if (fill < DEPTH) begin
                    byte_ring[tail_slot] = data;
                    tail_slot = (tail_slot + 1) % DEPTH;
                    fill++;
                end
                return;
            end
            // A tick on an empty queue produces nothing.
            if (fill == 0)
                return;
            head_byte = byte_ring[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
            fill--;

            // Register select is high for data bytes, low for commands.
            hi_word          = '0;
            hi_word[3:0]     = head_byte[7:4];
            hi_word[lcdq_pkg::RS_BIT] = !head_byte[lcdq_pkg::CMD_FLAG_BIT];
            lo_word          = hi_word;
            lo_word[3:0]     = head_byte[3:0];
            hi_pulse         = hi_word;
            hi_pulse[lcdq_pkg::EN_BIT] = 1'b1;
            lo_pulse         = lo_word;
            lo_pulse[lcdq_pkg::EN_BIT] = 1'b1;

            pending_words.push_back('{hi_word, 1'b0});
            pending_words.push_back('{hi_pulse, 1'b0});
            pending_words.push_back('{hi_word, 1'b0});
            pending_words.push_back('{lo_word, 1'b0});
            pending_words.push_back('{lo_pulse, 1'b0});
            pending_words.push_back('{lo_word, 1'b0});
            pending_words.push_back('{'0, 1'b1});
        endfunction

        function void check_word(logic [lcdq_pkg::WORD_W-1:0] port_word, logic last_word);
            port_beat_t want;
            if (pending_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word %02h last %0b",
                                        port_word, last_word));
                return;
            end
            want = pending_words.pop_front();
            if (port_word !== want.port_word || last_word !== want.last_word)
                flag_mismatch($sformatf("expected word %02h last %0b, got %02h last %0b",
                                        want.port_word, want.last_word,
                                        port_word, last_word));
        endfunction
    endclass

    logic                        aclk      = 1'b0;
    logic                        aresetn   = 1'b0;
    logic                        s_valid   = 1'b0;
    logic                        s_ready;
    logic                        s_op      = lcdq_pkg::OP_ENQUEUE;
    logic [lcdq_pkg::BYTE_W-1:0] s_byte_in = '0;
    logic                        m_valid;
    logic                        m_ready   = 1'b0;
    logic [lcdq_pkg::WORD_W-1:0] m_port_word;
    logic                        m_last_word;

    nibble_word_tracker tracker = new();

    // Words delivered so far; steers the receiver's stall pattern.
    int words_seen  = 0;
    // Consecutive cycles in which neither channel moved anything.
    int quiet_count = 0;
    // Set while the sender runs its stretch without any gaps.
    bit sender_calm = 1'b0;

    lcd_nibble_write_queue_core #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_op       (s_op),
        .s_byte_in  (s_byte_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_port_word(m_port_word),
        .m_last_word(m_last_word)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Monitor. Results are checked before the request of the same edge is
    // noted, so a word can never be matched against its own request's
    // prediction in the cycle that request is taken.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                tracker.check_word(m_port_word, m_last_word);
                words_seen <= words_seen + 1;
            end
            if (s_valid && s_ready)
                tracker.note_request(s_op, s_byte_in);
            if ((m_valid && m_ready) || (s_valid && s_ready))
                quiet_count <= 0;
            else
                quiet_count <= quiet_count + 1;
        end
    end

    // Offers one request, possibly after a random gap, and returns in the
    // step of the edge that accepts it. Valid stays high for a following
    // request unless a gap is chosen.
    task automatic offer_request(input logic op, input logic [lcdq_pkg::BYTE_W-1:0] data);
        if (!sender_calm && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_op      <= op;
        s_byte_in <= data;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver. It stalls at random, keeps a stretch without stalls, and
    // once holds off for a long time while the sender keeps offering, so
    // the core backs up and drops s_ready.
    initial begin
        bit held_off;
        held_off = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (!held_off && words_seen >= HOLD_AT_WORD) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (words_seen >= CALM_FIRST && words_seen < CALM_LAST)
                m_ready <= 1'b1;
            else
                m_ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: a correct run never goes this long without a transfer.
    initial begin
        @(posedge aclk);
        while (quiet_count < QUIET_LIMIT) @(posedge aclk);
        $display("lcd_nibble_write_queue_core: mismatch");
        $finish;
    end

    // Stimulus and verdict.
    initial begin
        int   enq_pct;
        int   item;
        logic op;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: a tick on an empty queue, the byte extremes for
        // both data and command bytes, pops with junk on byte_in, and a
        // final tick once the queue has run dry.
        offer_request(lcdq_pkg::OP_TICK, 8'hFF);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'h00);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'hFF);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'h80);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'h7F);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'h5A);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'hA5);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'h0F);
        offer_request(lcdq_pkg::OP_ENQUEUE, 8'hF0);
        offer_request(lcdq_pkg::OP_TICK, 8'h00);
        offer_request(lcdq_pkg::OP_TICK, 8'hFF);
        offer_request(lcdq_pkg::OP_TICK, 8'h55);
        offer_request(lcdq_pkg::OP_TICK, 8'hAA);
        offer_request(lcdq_pkg::OP_TICK, 8'h80);
        offer_request(lcdq_pkg::OP_TICK, 8'h7F);
        offer_request(lcdq_pkg::OP_TICK, 8'h0F);
        offer_request(lcdq_pkg::OP_TICK, 8'hF0);
        offer_request(lcdq_pkg::OP_TICK, 8'h3C);

        // Random part. It first pushes the queue well past full so that
        // enqueues get dropped, then drains it into empty ticks, then mixes
        // phases of random bias. The sender runs without gaps for a while.
        for (item = 0; item < 220; item++) begin
            if (item < 50)
                enq_pct = 92;
            else if (item < 100)
                enq_pct = 8;
            else if (item % 30 == 0)
                enq_pct = $urandom_range(20, 80);
            sender_calm = (item >= 110 && item < 170);
            op = ($urandom_range(99) < enq_pct) ? lcdq_pkg::OP_ENQUEUE : lcdq_pkg::OP_TICK;
            offer_request(op, 8'($urandom_range(255)));
        end
        s_valid <= 1'b0;

        // One more edge so the monitor has noted the last accepted request.
        @(posedge aclk);
        while (tracker.pending_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (tracker.mismatches == 0 && tracker.pending_words.size() == 0)
            $display("lcd_nibble_write_queue_core: match");
        else
            $display("lcd_nibble_write_queue_core: mismatch");
        $finish;
    end

endmodule
